/* hw/rtl/rect_highlight_alpha_blend_core_macros.svh */
// Assertion macros for the rectangle highlight blend core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RECT_HIGHLIGHT_ALPHA_BLEND_CORE_MACROS_SVH
`define RECT_HIGHLIGHT_ALPHA_BLEND_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RHA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RHA_ASSERT_SAME(label, clk, rst, ante, cons)
`define RHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/rha_pkg.sv */
// Shared types, constants and helpers for the rectangle highlight blend core.
// No dependencies.
`timescale 1ns / 1ps
package rha_pkg;
   localparam int CH_W       = 8;
   localparam int COORD_W    = 16;
   localparam int ALPHA_W    = 9;
   localparam int RECT_POS_W = 17;
   localparam int COLOR_W    = 3 * CH_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 2 * COORD_W + 3 * CH_W;
   localparam int RSP_DATA_W = 3 * CH_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_INIT = 9'd128;
   localparam logic [COLOR_W-1:0] COLOR_INIT = 24'hFFFF00;
   localparam logic [CH_W-1:0]    MAXV_INIT  = 8'd255;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RECT_X     = 3'd0,
      CSR_RECT_Y     = 3'd1,
      CSR_RECT_W     = 3'd2,
      CSR_RECT_H     = 3'd3,
      CSR_ALPHA      = 3'd4,
      CSR_COLOR      = 3'd5,
      CSR_MAX_VALUE  = 3'd6,
      CSR_IMAGE_SIZE = 3'd7
   } csr_index_type;

   // settings derived from the registers, ready for the datapath
   typedef struct packed {
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] x_hi;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] y_hi;
      logic [ALPHA_W-1:0] alpha;
      logic [CH_W-1:0]    ov_red;
      logic [CH_W-1:0]    ov_green;
      logic [CH_W-1:0]    ov_blue;
      logic [CH_W-1:0]    max_value;
   } cfg_type;

   // round(h * mv / 255); division by 255 via x/255 = (x + (x >> 8) + 1) >> 8
   function automatic logic [CH_W-1:0] scale_color(input logic [CH_W-1:0] h,
                                                   input logic [CH_W-1:0] mv);
      logic [15:0] p;
      logic [16:0] s;
      p = 16'(h) * 16'(mv) + 16'd127;
      s = {1'b0, p} + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction
endpackage

/* hw/rtl/rha_cfg.sv */
// Configuration register file and derived settings (clip window, scaled color).
// Depends on rha_pkg.
`timescale 1ns / 1ps
module rha_cfg
   import rha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);
   logic [RECT_POS_W-1:0] rect_x_ff;
   logic [RECT_POS_W-1:0] rect_y_ff;
   logic [COORD_W-1:0]    rect_w_ff;
   logic [COORD_W-1:0]    rect_h_ff;
   logic [ALPHA_W-1:0]    alpha_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic [CH_W-1:0]       maxv_ff;
   logic [2*COORD_W-1:0]  size_ff;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [RECT_POS_W:0]   x_sum;
   logic [RECT_POS_W:0]   y_sum;
   logic [COORD_W-1:0]    img_w;
   logic [COORD_W-1:0]    img_h;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff <= '0;
         rect_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         alpha_ff  <= ALPHA_INIT;
         color_ff  <= COLOR_INIT;
         maxv_ff   <= MAXV_INIT;
         size_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RECT_X:     rect_x_ff <= csr_wdata[RECT_POS_W-1:0];
            CSR_RECT_Y:     rect_y_ff <= csr_wdata[RECT_POS_W-1:0];
            CSR_RECT_W:     rect_w_ff <= csr_wdata[COORD_W-1:0];
            CSR_RECT_H:     rect_h_ff <= csr_wdata[COORD_W-1:0];
            CSR_ALPHA:      alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_COLOR:      color_ff  <= csr_wdata[COLOR_W-1:0];
            CSR_MAX_VALUE:  maxv_ff   <= csr_wdata[CH_W-1:0];
            CSR_IMAGE_SIZE: size_ff   <= csr_wdata[2*COORD_W-1:0];
            default:        ;
         endcase
      end
   end

   assign img_w = size_ff[COORD_W-1:0];
   assign img_h = size_ff[2*COORD_W-1:COORD_W];
   assign x_sum = {rect_x_ff[RECT_POS_W-1], rect_x_ff} + {2'b00, rect_w_ff};
   assign y_sum = {rect_y_ff[RECT_POS_W-1], rect_y_ff} + {2'b00, rect_h_ff};

   always_comb begin
      cfg_in.x_lo = rect_x_ff[RECT_POS_W-1] ? '0 : rect_x_ff[COORD_W-1:0];
      cfg_in.y_lo = rect_y_ff[RECT_POS_W-1] ? '0 : rect_y_ff[COORD_W-1:0];
      // negative right/bottom edge leaves an empty window
      priority if (x_sum[RECT_POS_W]) begin
         cfg_in.x_hi = '0;
      end else if (x_sum[RECT_POS_W-1:0] > {1'b0, img_w}) begin
         cfg_in.x_hi = img_w;
      end else begin
         cfg_in.x_hi = x_sum[COORD_W-1:0];
      end
      priority if (y_sum[RECT_POS_W]) begin
         cfg_in.y_hi = '0;
      end else if (y_sum[RECT_POS_W-1:0] > {1'b0, img_h}) begin
         cfg_in.y_hi = img_h;
      end else begin
         cfg_in.y_hi = y_sum[COORD_W-1:0];
      end
      cfg_in.alpha     = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      cfg_in.ov_red    = scale_color(color_ff[3*CH_W-1:2*CH_W], maxv_ff);
      cfg_in.ov_green  = scale_color(color_ff[2*CH_W-1:CH_W], maxv_ff);
      cfg_in.ov_blue   = scale_color(color_ff[CH_W-1:0], maxv_ff);
      cfg_in.max_value = maxv_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;
endmodule

/* hw/rtl/rha_blend_ch.sv */
// One-channel alpha blend toward the overlay value, clamped to max_value.
// Depends on rha_pkg.
`timescale 1ns / 1ps
module rha_blend_ch
   import rha_pkg::*;
(
   input  logic [CH_W-1:0]    orig,
   input  logic [CH_W-1:0]    ov,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [CH_W-1:0]    max_value,
   output logic [CH_W-1:0]    result
);
   logic [ALPHA_W-1:0]      inv_alpha;
   logic [ALPHA_W+CH_W-1:0] prod_orig;
   logic [ALPHA_W+CH_W-1:0] prod_ov;
   logic [ALPHA_W+CH_W:0]   sum;
   logic [CH_W+1:0]         mixed;

   assign inv_alpha = ALPHA_ONE - alpha;
   assign prod_orig = (ALPHA_W+CH_W)'(inv_alpha) * (ALPHA_W+CH_W)'(orig);
   assign prod_ov   = (ALPHA_W+CH_W)'(alpha) * (ALPHA_W+CH_W)'(ov);
   assign sum = (ALPHA_W+CH_W+1)'(prod_orig) + (ALPHA_W+CH_W+1)'(prod_ov)
              + (ALPHA_W+CH_W+1)'(ALPHA_ONE >> 1);
   assign mixed = sum[ALPHA_W+CH_W:ALPHA_W-1];
   assign result = (mixed > (CH_W+2)'(max_value)) ? max_value : mixed[CH_W-1:0];
endmodule

/* hw/rtl/rect_highlight_alpha_blend_core.sv */
// Top level of the rectangle highlight blend core: input register, window test,
// three channel blends, result register. Depends on rha_pkg, rha_cfg, rha_blend_ch.
//
//  channel   ports          payload (low bit first)
//  request   req_*          tdata: pix_x, pix_y, in_red, in_green, in_blue
//  response  rsp_*          tdata: out_red, out_green, out_blue; tuser: highlighted
//  csr       csr_*          addr: register index, wdata: value
//
// One pixel per clock unless stalled; stages: input register, result register.
// A csr write is registered, then the derived clip window and color are registered.
// Both pipeline stages hold while the response is stalled; req_tready follows.
// Reset is synchronous and restores the documented register defaults.
`timescale 1ns / 1ps
`include "rect_highlight_alpha_blend_core_macros.svh"
module rect_highlight_alpha_blend_core
   import rha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pix_x, pix_y, in_red, in_green, in_blue
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_red, out_green, out_blue
   output logic                  rsp_tuser,  // highlighted
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type cfg;

   logic                  advance;
   logic                  s1_valid_ff;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_hl_ff;

   logic [COORD_W-1:0]    pix_x;
   logic [COORD_W-1:0]    pix_y;
   logic [CH_W-1:0]       in_red;
   logic [CH_W-1:0]       in_green;
   logic [CH_W-1:0]       in_blue;
   logic [CH_W-1:0]       bl_red;
   logic [CH_W-1:0]       bl_green;
   logic [CH_W-1:0]       bl_blue;
   logic                  in_rect;

   rha_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s1_data_ff <= req_tdata;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_hl_ff   <= in_rect;
      end
   end

   assign pix_x    = s1_data_ff[COORD_W-1:0];
   assign pix_y    = s1_data_ff[2*COORD_W-1:COORD_W];
   assign in_red   = s1_data_ff[2*COORD_W+CH_W-1:2*COORD_W];
   assign in_green = s1_data_ff[2*COORD_W+2*CH_W-1:2*COORD_W+CH_W];
   assign in_blue  = s1_data_ff[2*COORD_W+3*CH_W-1:2*COORD_W+2*CH_W];

   assign in_rect = (pix_x >= cfg.x_lo) && (pix_x < cfg.x_hi)
                 && (pix_y >= cfg.y_lo) && (pix_y < cfg.y_hi);

   rha_blend_ch u_blend_red (
      .orig      (in_red),
      .ov        (cfg.ov_red),
      .alpha     (cfg.alpha),
      .max_value (cfg.max_value),
      .result    (bl_red)
   );

   rha_blend_ch u_blend_green (
      .orig      (in_green),
      .ov        (cfg.ov_green),
      .alpha     (cfg.alpha),
      .max_value (cfg.max_value),
      .result    (bl_green)
   );

   rha_blend_ch u_blend_blue (
      .orig      (in_blue),
      .ov        (cfg.ov_blue),
      .alpha     (cfg.alpha),
      .max_value (cfg.max_value),
      .result    (bl_blue)
   );

   assign rsp_data_in = in_rect ? {bl_blue, bl_green, bl_red}
                                : {in_blue, in_green, in_red};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hl_ff;

   `RHA_ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, s1_valid_ff)
   `RHA_ASSERT_NEXT(a_pass_through, clock, reset, advance && s1_valid_ff && !in_rect, rsp_tdata == $past(s1_data_ff[REQ_DATA_W-1:2*COORD_W]))
   `RHA_ASSERT_SAME(a_blend_clamped, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[CH_W-1:0] <= cfg.max_value && rsp_tdata[2*CH_W-1:CH_W] <= cfg.max_value && rsp_tdata[3*CH_W-1:2*CH_W] <= cfg.max_value)
endmodule

/* verif/rect_highlight_alpha_blend_core_tb.sv */
// Self-checking testbench for rect_highlight_alpha_blend_core: streams pixels with a built-in
// blend predictor, checks every response field and varies handshake idling and csr settings.
// Depends on rha_pkg and the core RTL only.
`timescale 1ns / 1ps
module rect_highlight_alpha_blend_core_tb;
   import rha_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] pix_x;
      logic [COORD_W-1:0] pix_y;
      logic [CH_W-1:0]    red;
      logic [CH_W-1:0]    green;
      logic [CH_W-1:0]    blue;
   } pixel_type;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            highlighted;
   } blend_result_type;

   localparam int REG_BITS [8] = '{17, 17, 16, 16, 9, 24, 8, 32};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the register file
   logic signed [16:0] rect_x_q = '0;
   logic signed [16:0] rect_y_q = '0;
   logic [15:0]        rect_w_q = '0;
   logic [15:0]        rect_h_q = '0;
   logic [ALPHA_W-1:0] alpha_q  = ALPHA_INIT;
   logic [COLOR_W-1:0] color_q  = COLOR_INIT;
   logic [CH_W-1:0]    maxv_q   = MAXV_INIT;
   logic [31:0]        isize_q  = '0;

   blend_result_type pending_blends[$];
   int mismatches = 0;
   int pixels_sent = 0;
   int pixels_highlighted = 0;
   int settings_loaded = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stall_hold = 0;

   rect_highlight_alpha_blend_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] orig,
                                                    input logic [CH_W-1:0] hue,
                                                    input int a);
      int o, h, m, ov, n;
      o = orig;
      h = hue;
      m = maxv_q;
      ov = (h * m + 127) / 255;
      n = ((256 - a) * o + a * ov + 128) >> 8;
      if (n > m) n = m;
      return n[CH_W-1:0];
   endfunction

   function automatic blend_result_type blend_pixel(input pixel_type p);
      blend_result_type r;
      int rx, ry, rw, rh, iw, ih, x0, y0, x1, y1, px, py, a;
      rx = rect_x_q;
      ry = rect_y_q;
      rw = rect_w_q;
      rh = rect_h_q;
      iw = isize_q[15:0];
      ih = isize_q[31:16];
      px = p.pix_x;
      py = p.pix_y;
      x0 = (rx < 0) ? 0 : rx;
      y0 = (ry < 0) ? 0 : ry;
      x1 = rx + rw;
      y1 = ry + rh;
      if (x1 > iw) x1 = iw;
      if (y1 > ih) y1 = ih;
      r.highlighted = (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
      a = alpha_q;
      if (a > 256) a = 256;
      if (r.highlighted) begin
         r.red   = mix_channel(p.red,   color_q[23:16], a);
         r.green = mix_channel(p.green, color_q[15:8],  a);
         r.blue  = mix_channel(p.blue,  color_q[7:0],   a);
      end else begin
         r.red   = p.red;
         r.green = p.green;
         r.blue  = p.blue;
      end
      return r;
   endfunction

   function automatic pixel_type make_pixel(input int x, input int y, input int r,
                                            input int g, input int b);
      pixel_type p;
      p.pix_x = x[15:0];
      p.pix_y = y[15:0];
      p.red   = r[7:0];
      p.green = g[7:0];
      p.blue  = b[7:0];
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      if ($urandom_range(3) != 0) begin
         p.pix_x = 16'($urandom_range(0, 50));
         p.pix_y = 16'($urandom_range(0, 50));
      end else begin
         p.pix_x = 16'($urandom);
         p.pix_y = 16'($urandom);
      end
      p.red   = 8'($urandom);
      p.green = 8'($urandom);
      p.blue  = 8'($urandom);
      return p;
   endfunction

   task automatic send_pixel(input pixel_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.blue, p.green, p.red, p.pix_y, p.pix_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_blends.push_back(blend_pixel(p));
      pixels_sent++;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RECT_X:     rect_x_q = value[16:0];
         CSR_RECT_Y:     rect_y_q = value[16:0];
         CSR_RECT_W:     rect_w_q = value[15:0];
         CSR_RECT_H:     rect_h_q = value[15:0];
         CSR_ALPHA:      alpha_q  = value[8:0];
         CSR_COLOR:      color_q  = value[23:0];
         CSR_MAX_VALUE:  maxv_q   = value[7:0];
         CSR_IMAGE_SIZE: isize_q  = value;
         default: ;
      endcase
   endtask

   // unused upper bits of each write carry random junk
   task automatic load_settings(input int rx, input int ry, input int rw, input int rh,
                                input int alpha, input logic [23:0] color, input int maxv,
                                input logic [31:0] isize);
      logic [31:0] vals [8];
      logic [31:0] mask;
      vals = '{rx, ry, rw, rh, alpha, {8'd0, color}, maxv, isize};
      for (int i = 0; i < 8; i++) begin
         mask = (REG_BITS[i] == 32) ? '1 : ((32'd1 << REG_BITS[i]) - 32'd1);
         write_reg(csr_index_type'(i), (vals[i] & mask) | ($urandom & ~mask));
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic load_random_settings();
      int rx, ry, rw, rh, alpha, maxv;
      logic [31:0] isize;
      case ($urandom_range(7))
         0: rx = -65536;
         1: rx = 65535;
         default: rx = int'($urandom_range(0, 40)) - 8;
      endcase
      case ($urandom_range(7))
         0: ry = -65536;
         1: ry = 65535;
         default: ry = int'($urandom_range(0, 40)) - 8;
      endcase
      rw = ($urandom_range(7) == 0) ? 65535 : $urandom_range(0, 40);
      rh = ($urandom_range(7) == 0) ? 65535 : $urandom_range(0, 40);
      case ($urandom_range(7))
         0: alpha = 0;
         1: alpha = 256;
         2: alpha = $urandom_range(257, 511);
         default: alpha = $urandom_range(0, 256);
      endcase
      case ($urandom_range(7))
         0: maxv = 0;
         1: maxv = 255;
         default: maxv = $urandom_range(1, 255);
      endcase
      case ($urandom_range(7))
         0: isize = $urandom;
         1: isize = '0;
         default: isize = {16'($urandom_range(0, 48)), 16'($urandom_range(0, 48))};
      endcase
      load_settings(rx, ry, rw, rh, alpha, 24'($urandom), maxv, isize);
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (stall_hold > 0) begin
         rsp_tready <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blends.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual tdata=%h tuser=%b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_blends.pop_front();
            check_field("out_red",     want.red,         rsp_tdata[7:0]);
            check_field("out_green",   want.green,       rsp_tdata[15:8]);
            check_field("out_blue",    want.blue,        rsp_tdata[23:16]);
            check_field("highlighted", want.highlighted, rsp_tuser);
            if (want.highlighted) pixels_highlighted++;
         end
      end
   end

   task automatic test_reset_defaults();
      send_pixel(make_pixel(0, 0, 0, 0, 0));
      send_pixel(make_pixel(65535, 65535, 255, 255, 255));
      wait_quiet();
   endtask

   task automatic test_clip_edges();
      load_settings(10, 20, 5, 4, 128, 24'h12ABFF, 255, {16'd100, 16'd100});
      send_pixel(make_pixel(10, 20, 0, 128, 255));
      send_pixel(make_pixel(14, 23, 255, 0, 77));
      send_pixel(make_pixel(9, 20, 1, 2, 3));
      send_pixel(make_pixel(15, 20, 1, 2, 3));
      send_pixel(make_pixel(10, 19, 1, 2, 3));
      send_pixel(make_pixel(10, 24, 1, 2, 3));
      wait_quiet();
      // negative origin, window lying inside the full image size; alpha above one
      load_settings(-5, -3, 65535, 65535, 511, 24'h00FF80, 255, 32'hFFFF_FFFF);
      send_pixel(make_pixel(0, 0, 200, 100, 50));
      send_pixel(make_pixel(65529, 65531, 9, 9, 9));
      send_pixel(make_pixel(65535, 0, 9, 9, 9));
      wait_quiet();
      // rectangle beyond the image and at the far edge: nothing highlighted
      load_settings(65535, -65536, 65535, 65535, 256, 24'hFFFFFF, 255, 32'h0);
      send_pixel(make_pixel(65535, 0, 10, 20, 30));
      wait_quiet();
   endtask

   task automatic test_special_values();
      load_settings(0, 0, 4, 4, 0, 24'hFFFFFF, 0, {16'd4, 16'd4});
      send_pixel(make_pixel(0, 0, 255, 128, 1));
      send_pixel(make_pixel(4, 0, 200, 201, 202));
      wait_quiet();
      load_settings(0, 0, 4, 4, 256, 24'hFFFFFF, 1, {16'd4, 16'd4});
      send_pixel(make_pixel(1, 1, 255, 0, 1));
      send_pixel(make_pixel(3, 3, 0, 0, 0));
      wait_quiet();
      load_settings(0, 0, 4, 4, 0, 24'h000000, 100, {16'd4, 16'd4});
      send_pixel(make_pixel(2, 2, 255, 100, 99));
      send_pixel(make_pixel(2, 4, 255, 101, 99));
      wait_quiet();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      load_settings(0, 0, 64, 64, 200, 24'h3366CC, 255, {16'd64, 16'd64});
      stall_hold <= 200;
      repeat (40) send_pixel(random_pixel());
      wait_quiet();
      repeat (10) send_pixel(random_pixel());
      wait_quiet();
   endtask

   task automatic test_random_traffic();
      int idle_mix [5][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{34, 34}, '{0, 0}};
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = idle_mix[ph][0];
         stall_pct = idle_mix[ph][1];
         repeat (6) begin
            load_random_settings();
            repeat (25) send_pixel(random_pixel());
            wait_quiet();
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_clip_edges();
      test_special_values();
      test_backpressure();
      test_random_traffic();
      wait_quiet();
      repeat (8) @(posedge clock);
      $display("Covered %0d pixels, %0d highlighted, over %0d register settings",
               pixels_sent, pixels_highlighted, settings_loaded);
      if (mismatches == 0 && pending_blends.size() == 0) begin
         $display("[rect_highlight_alpha_blend_core] OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_blends.size());
         $display("[rect_highlight_alpha_blend_core] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", pending_blends.size());
      $display("[rect_highlight_alpha_blend_core] ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rha_pkg.sv
hw/rtl/rha_cfg.sv
hw/rtl/rha_blend_ch.sv
hw/rtl/rect_highlight_alpha_blend_core.sv
verif/rect_highlight_alpha_blend_core_tb.sv
